[rtl/bms_pkg.sv]
// Package for the Boyer-Moore byte-stream search block.
// Shared types, sizes and helpers; no dependencies.
package bms_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_BITS    = 8 * MAX_PATTERN;
    localparam int POS_WIDTH   = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int CFG_IDX_W   = 3;

    typedef logic [7:0]          octet_t;
    typedef logic [5:0]          shift_t;
    typedef logic [4:0]          pidx_t;
    typedef logic [POS_WIDTH-1:0] pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_LEN  = 3'd4
    } cfg_reg_t;

    // Clamp the programmed length into 1..MAX_PATTERN.
    function automatic shift_t eff_len(input shift_t len);
        shift_t r;
        r = len;
        if (len == 6'd0) r = 6'd1;
        else if (len > 6'(MAX_PATTERN)) r = 6'(MAX_PATTERN);
        return r;
    endfunction

endpackage

[rtl/boyer_moore_search.sv]
// Top level of the Boyer-Moore byte-stream search block.
// Depends on bms_pkg, bms_front, bms_gs_build and bms_back.
//
// Text bytes stream in on the s_ channel, one per transaction, with tlast on the final byte.
// Each match yields a transaction on the m_ channel carrying the start offset (modulo 2^32)
// with tuser high; the final byte always yields a transaction with tlast high, merged with
// a match that ends on that byte. A four-entry queue decouples intake from the search engine.
// The engine handles each text byte in three steps (dequeue, compare against all pattern taps,
// shift update) and takes no new byte until the last is done; results backing up stall it.
// After any pattern write, the first byte of the next text triggers a good-suffix build that
// tries one candidate shift per cycle. cfg_ready stays low while the queue holds bytes or
// the engine is busy, so a write lands only once every accepted byte has been processed.
// Pattern writes are taken only between texts; writes in the middle of a text are dropped.
module boyer_moore_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] match_pos
    output logic        m_tuser,   // found
    output logic        m_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [bms_pkg::PAT_BITS-1:0]              pat_reg;
    bms_pkg::shift_t                           len_reg, m_len;
    logic                                      ready_reg;
    logic                                      q_valid, q_last, q_pop;
    bms_pkg::octet_t                           q_byte;
    logic                                      build_start, build_done, text_idle;
    logic                                      eng_idle;
    bms_pkg::shift_t [bms_pkg::MAX_PATTERN-1:0] good;
    logic                                      cfg_take;

    // Hold writes off until every accepted byte has left the engine.
    assign cfg_ready = !q_valid && eng_idle;
    assign m_len     = bms_pkg::eff_len(len_reg);
    // Drop writes to unknown indexes and writes in the middle of a text.
    assign cfg_take  = cfg_valid && cfg_ready && text_idle
                       && cfg_index <= bms_pkg::CFG_IDX_W'(bms_pkg::REG_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg   <= '0;
            len_reg   <= 6'd1;
            ready_reg <= 1'b0;
        end else begin
            if (cfg_take) begin
                unique case (cfg_index)
                    bms_pkg::REG_PAT0: pat_reg[63:0]    <= cfg_data;
                    bms_pkg::REG_PAT1: pat_reg[127:64]  <= cfg_data;
                    bms_pkg::REG_PAT2: pat_reg[191:128] <= cfg_data;
                    bms_pkg::REG_PAT3: pat_reg[255:192] <= cfg_data;
                    bms_pkg::REG_LEN:  len_reg          <= cfg_data[5:0];
                    default: ;
                endcase
                ready_reg <= 1'b0;
            end else if (build_done) begin
                ready_reg <= 1'b1;
            end
        end
    end

    bms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_valid  (q_valid),
        .q_byte   (q_byte),
        .q_last   (q_last),
        .q_pop    (q_pop)
    );

    bms_gs_build u_gs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (build_start),
        .pattern (pat_reg),
        .len     (m_len),
        .done    (build_done),
        .good    (good)
    );

    bms_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_byte       (q_byte),
        .q_last       (q_last),
        .q_pop        (q_pop),
        .pattern      (pat_reg),
        .len          (m_len),
        .tables_ready (ready_reg),
        .good         (good),
        .build_start  (build_start),
        .text_idle    (text_idle),
        .eng_idle     (eng_idle),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_pos        (m_tdata),
        .m_found      (m_tuser),
        .m_done       (m_tlast)
    );

endmodule

[rtl/bms_front.sv]
// Front queue of the search block: accepts text bytes and holds them for the back end.
// Depends on bms_pkg.
module bms_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  bms_pkg::octet_t in_byte,
    input  logic            in_last,
    output logic            q_valid,
    output bms_pkg::octet_t q_byte,
    output logic            q_last,
    input  logic            q_pop
);

    bms_pkg::octet_t                byte_reg [bms_pkg::FIFO_DEPTH];
    logic [bms_pkg::FIFO_DEPTH-1:0] last_reg;
    logic [bms_pkg::FIFO_AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [bms_pkg::FIFO_AW:0]      cnt_reg, cnt_next;
    logic                           push, pop;

    assign s_tready = (cnt_reg != (bms_pkg::FIFO_AW+1)'(bms_pkg::FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_byte   = byte_reg[rd_reg];
    assign q_last   = last_reg[rd_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            byte_reg[wr_reg] <= in_byte;
            last_reg[wr_reg] <= in_last;
        end
    end

endmodule

[rtl/bms_gs_build.sv]
// Good-suffix table builder: tries one shift per cycle for each mismatch position.
// Depends on bms_pkg.
module bms_gs_build (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [bms_pkg::PAT_BITS-1:0]             pattern,
    input  bms_pkg::shift_t                          len,
    output logic                                     done,
    output bms_pkg::shift_t [bms_pkg::MAX_PATTERN-1:0] good
);

    typedef enum logic [1:0] {
        GS_IDLE = 2'b01,
        GS_RUN  = 2'b10
    } gs_state_t;

    gs_state_t                                 state_reg, state_next;
    bms_pkg::pidx_t                            j_reg, j_next;
    bms_pkg::shift_t                           s_reg, s_next;
    bms_pkg::shift_t [bms_pkg::MAX_PATTERN-1:0] good_reg;
    logic [bms_pkg::PAT_BITS-1:0]              sh;
    logic                                      ok;

    assign good = good_reg;

    // A shift s is valid for mismatch at j when the matched suffix re-aligns
    // and the byte at j differs (or falls off the pattern head).
    always_comb begin
        sh = pattern << {s_reg, 3'b000};
        ok = 1'b1;
        for (int k = 0; k < bms_pkg::MAX_PATTERN; k++) begin
            if (6'(k) < len && 6'(k) > {1'b0, j_reg} && 6'(k) >= s_reg
                && sh[8*k +: 8] != pattern[8*k +: 8])
                ok = 1'b0;
            if (6'(k) == {1'b0, j_reg} && 6'(k) >= s_reg
                && sh[8*k +: 8] == pattern[8*k +: 8])
                ok = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        done       = 1'b0;
        unique case (state_reg)
            GS_IDLE: begin
                if (start) begin
                    state_next = GS_RUN;
                    j_next     = '0;
                    s_next     = 6'd1;
                end
            end
            GS_RUN: begin
                if (ok) begin
                    s_next = 6'd1;
                    if ({1'b0, j_reg} == len - 6'd1) begin
                        done       = 1'b1;
                        state_next = GS_IDLE;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    s_next = s_reg + 6'd1;
                end
            end
            default: state_next = GS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= GS_IDLE;
            j_reg     <= '0;
            s_reg     <= 6'd1;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            s_reg     <= s_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == GS_RUN && ok) good_reg[j_reg] <= s_reg;
    end

endmodule

[rtl/bms_back.sv]
// Back end of the search: tap line of recent bytes, alignment test and shift update.
// Depends on bms_pkg.
module bms_back (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     q_valid,
    input  bms_pkg::octet_t                          q_byte,
    input  logic                                     q_last,
    output logic                                     q_pop,
    input  logic [bms_pkg::PAT_BITS-1:0]             pattern,
    input  bms_pkg::shift_t                          len,
    input  logic                                     tables_ready,
    input  bms_pkg::shift_t [bms_pkg::MAX_PATTERN-1:0] good,
    output logic                                     build_start,
    output logic                                     text_idle,
    output logic                                     eng_idle,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output bms_pkg::pos_t                            m_pos,
    output logic                                     m_found,
    output logic                                     m_done
);

    typedef enum logic [3:0] {
        BK_IDLE  = 4'b0001,
        BK_BUILD = 4'b0010,
        BK_CMP   = 4'b0100,
        BK_UPD   = 4'b1000
    } bk_state_t;

    bk_state_t       state_reg, state_next;
    bms_pkg::octet_t win_reg [bms_pkg::MAX_PATTERN];
    bms_pkg::pos_t   align_reg, align_next, seen_reg, seen_next;
    logic            last_reg, tested_reg, hit_reg;
    bms_pkg::pidx_t  mp_reg, mis_p;
    bms_pkg::octet_t mc_reg;
    logic            mis_found;
    logic [bms_pkg::PAT_BITS-1:0] pat_al;
    logic            ov_reg, found_reg, done_reg;
    bms_pkg::pos_t   opos_reg;
    logic            out_free, emit, advance;
    bms_pkg::pidx_t  mi, bj;
    logic            bf;
    logic signed [6:0] bc;
    bms_pkg::shift_t shift;
    logic            pop_now;

    assign m_tvalid  = ov_reg;
    assign m_pos     = opos_reg;
    assign m_found   = found_reg;
    assign m_done    = done_reg;
    assign text_idle = (seen_reg == '0);
    assign eng_idle  = (state_reg == BK_IDLE);
    assign out_free  = !ov_reg || m_tready;

    // Place pattern byte i beside tap (32 - len + i); newest byte sits on the top tap.
    always_comb begin
        pat_al    = pattern << {(6'd32 - len), 3'b000};
        mis_found = 1'b0;
        mis_p     = '0;
        for (int p = 0; p < bms_pkg::MAX_PATTERN; p++) begin
            if (6'(p) >= 6'd32 - len && win_reg[p] != pat_al[8*p +: 8]) begin
                mis_found = 1'b1;
                mis_p     = 5'(p);
            end
        end
    end

    // Shift after a mismatch: max of good-suffix and bad-character rules.
    always_comb begin
        mi = 5'(mp_reg + len[4:0]);
        bf = 1'b0;
        bj = '0;
        for (int j = 0; j < bms_pkg::MAX_PATTERN - 1; j++) begin
            if (6'(j) < len - 6'd1 && pattern[8*j +: 8] == mc_reg) begin
                bf = 1'b1;
                bj = 5'(j);
            end
        end
        bc    = bf ? $signed({2'b00, mi}) - $signed({2'b00, bj})
                   : $signed({2'b00, mi}) + 7'sd1;
        shift = (bc > $signed({1'b0, good[mi]})) ? bc[5:0] : good[mi];
    end

    always_comb begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        pop_now     = 1'b0;
        build_start = 1'b0;
        emit        = 1'b0;
        advance     = 1'b0;
        align_next  = align_reg;
        seen_next   = seen_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (seen_reg == '0 && !tables_ready) begin
                        build_start = 1'b1;
                        state_next  = BK_BUILD;
                    end else begin
                        q_pop      = 1'b1;
                        pop_now    = 1'b1;
                        state_next = BK_CMP;
                    end
                end
            end
            BK_BUILD: begin
                if (tables_ready) state_next = BK_IDLE;
            end
            BK_CMP: state_next = BK_UPD;
            BK_UPD: begin
                if (!((tested_reg && hit_reg) || last_reg) || out_free) begin
                    advance    = 1'b1;
                    emit       = (tested_reg && hit_reg) || last_reg;
                    state_next = BK_IDLE;
                    if (tested_reg)
                        align_next = align_reg + (hit_reg ? bms_pkg::POS_WIDTH'(good[0])
                                                          : bms_pkg::POS_WIDTH'(shift));
                    seen_next = seen_reg + 1'b1;
                    if (last_reg) begin
                        align_next = '0;
                        seen_next  = '0;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            align_reg <= '0;
            seen_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            align_reg <= align_next;
            seen_reg  <= seen_next;
            if (emit) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_now) begin
            for (int p = 0; p < bms_pkg::MAX_PATTERN - 1; p++) win_reg[p] <= win_reg[p+1];
            win_reg[bms_pkg::MAX_PATTERN-1] <= q_byte;
            last_reg   <= q_last;
            tested_reg <= (align_reg + bms_pkg::POS_WIDTH'(len - 6'd1)) == seen_reg;
        end
        if (state_reg == BK_CMP) begin
            hit_reg <= !mis_found;
            mp_reg  <= mis_p;
            mc_reg  <= win_reg[mis_p];
        end
        if (emit) begin
            opos_reg  <= (tested_reg && hit_reg) ? align_reg : '0;
            found_reg <= tested_reg && hit_reg;
            done_reg  <= last_reg;
        end
    end

endmodule

[tb/sv/tb_boyer_moore_search.sv]
// Testbench for boyer_moore_search: streams texts, predicts every match and end-of-text result.
// Depends on bms_pkg and the boyer_moore_search RTL.
`timescale 1ns / 1ps

module tb_boyer_moore_search;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] text_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] match_pos
    logic        m_tuser;   // found
    logic        m_tlast;   // done_res
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    boyer_moore_search dut (.*);

    typedef struct packed {
        logic [31:0] pos;
        logic        found;
        logic        done;
    } hit_t;

    // Predictor state
    logic [63:0] pat_words [4];
    logic [5:0]  pat_len_reg;
    logic [7:0]  window [64];
    logic [5:0]  bad_tab [256];
    logic [5:0]  good_tab [32];
    logic [31:0] align_pos;
    logic [31:0] seen;
    logic [5:0]  wptr;
    bit          tabs_ok;

    hit_t        hits_due [$];
    int          errors;
    bit          rx_hold;      // long receiver hold-off request
    int          rx_hold_cycles;
    int          rx_max_gap;
    int          tx_max_gap;

    // Clock: 12 ns period
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int plen();
        int m;
        m = pat_len_reg;
        if (m < 1) m = 1;
        if (m > 32) m = 32;
        return m;
    endfunction

    function automatic logic [7:0] pbyte(int i);
        return pat_words[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    // Build bad-character and good-suffix shift tables from the pattern.
    task automatic build_shifts();
        int m, i, j, f, g;
        int sfx [32];
        m = plen();
        f = 0;
        for (i = 0; i < 256; i++) bad_tab[i] = 6'(m);
        for (i = 0; i < m - 1; i++) bad_tab[pbyte(i)] = 6'(m - i - 1);
        sfx[m-1] = m;
        g = m - 1;
        for (i = m - 2; i >= 0; i--) begin
            if (i > g && sfx[i + m - 1 - f] < i - g) begin
                sfx[i] = sfx[i + m - 1 - f];
            end else begin
                if (i < g) g = i;
                f = i;
                while (g >= 0 && pbyte(g) == pbyte(g + m - 1 - f)) g--;
                sfx[i] = f - g;
            end
        end
        for (i = 0; i < m; i++) good_tab[i] = 6'(m);
        j = 0;
        for (i = m - 1; i >= 0; i--)
            if (sfx[i] == i + 1)
                for (; j < m - 1 - i; j++)
                    if (good_tab[j] == 6'(m)) good_tab[j] = 6'(m - 1 - i);
        for (i = 0; i <= m - 2; i++) good_tab[m - 1 - sfx[i]] = 6'(m - 1 - i);
        tabs_ok = 1'b1;
    endtask

    // Advance the predictor by one text byte; queue any expected result.
    task automatic predict_byte(logic [7:0] c, logic last);
        int m, i, bc, gs, s;
        bit hit;
        logic [31:0] hpos;
        hit = 1'b0;
        hpos = '0;
        if (seen == 0 && !tabs_ok) build_shifts();
        m = plen();
        window[wptr] = c;
        if (align_pos + 32'(m - 1) == seen) begin
            for (i = m - 1; i >= 0; i--)
                if (window[6'(wptr - 6'(m - 1 - i))] != pbyte(i)) break;
            if (i < 0) begin
                hit = 1'b1;
                hpos = align_pos;
                align_pos = align_pos + 32'(good_tab[0]);
            end else begin
                bc = int'(bad_tab[window[6'(wptr - 6'(m - 1 - i))]]) - m + 1 + i;
                gs = int'(good_tab[i]);
                s = gs > bc ? gs : bc;
                align_pos = align_pos + 32'(s);
            end
        end
        wptr = wptr + 6'd1;
        seen = seen + 32'd1;
        if (hit || last) hits_due.push_back('{pos: hpos, found: hit, done: last});
        if (last) begin
            seen = '0;
            align_pos = '0;
            wptr = '0;
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker: sample at the rising edge.
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hits_due.size() == 0) begin
                report("unexpected result", m_tdata, 32'd0);
            end else begin
                e = hits_due.pop_front();
                if (m_tuser !== e.found) report("found", 32'(m_tuser), 32'(e.found));
                if (m_tlast !== e.done) report("done", 32'(m_tlast), 32'(e.done));
                if (m_tdata !== e.pos) report("match_pos", m_tdata, e.pos);
            end
        end
    end

    // Receiver: random stalls, or a long hold when asked.
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold = 1'b0;
            end
            w = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            if (w != 0) begin
                m_tready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // Drop the input valid at the next falling edge.
    task automatic stop_tx();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Send one text byte; predict it when the transaction completes.
    // Return at the accepting edge with valid still high.
    task automatic send_byte(logic [7:0] c, logic last);
        int w;
        w = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        @(negedge aclk);
        if (w != 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(c, last);
    endtask

    task automatic write_reg(bms_pkg::cfg_reg_t idx, logic [63:0] val);
        stop_tx();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (seen == 0) begin
            if (idx == bms_pkg::REG_LEN) pat_len_reg = val[5:0];
            else pat_words[idx] = val;
            tabs_ok = 1'b0;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for all results, then let the engine settle before a write.
    task automatic drain();
        stop_tx();
        while (hits_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_pattern(logic [7:0] p [], int len_field);
        logic [63:0] w [4];
        for (int k = 0; k < 4; k++) w[k] = {$urandom, $urandom};
        foreach (p[k]) w[k >> 3][(k & 7) * 8 +: 8] = p[k];
        drain();
        for (int k = 0; k < 4; k++) write_reg(bms_pkg::cfg_reg_t'(k), w[k]);
        write_reg(bms_pkg::REG_LEN, 64'(len_field));
    endtask

    task automatic send_text(logic [7:0] t []);
        foreach (t[k]) send_byte(t[k], k == t.size() - 1);
    endtask

    // Text over a small alphabet (all byte values when alpha is 0) with the pattern planted often.
    task automatic random_text(int n, int alpha);
        int m, k;
        logic [7:0] c;
        m = plen();
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 3) == 0 && k + m <= n) begin
                for (int q = 0; q < m; q++) send_byte(pbyte(q), k + q == n - 1);
                k += m;
            end else begin
                c = (alpha == 0) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1) + 8'h61);
                send_byte(c, k == n - 1);
                k++;
            end
        end
    endtask

    task automatic test_directed();
        logic [7:0] p [];
        p = '{8'h00, 8'hff, 8'h00};
        set_pattern(p, 3);
        send_text('{8'h00, 8'hff, 8'h00, 8'hff, 8'h00});      // overlapping matches, end on match
        send_text('{8'h00});                                  // shorter than pattern
        set_pattern('{8'hab}, 0);                             // length 0 acts as 1
        send_text('{8'hab, 8'h12, 8'hab, 8'hab});
        set_pattern('{8'h55}, 63);                            // clamp to 32, random tail
        p = new[32];
        foreach (p[k]) p[k] = 8'($urandom);
        set_pattern(p, 32);
        send_text('{p[0], p[1]});
        write_reg(bms_pkg::REG_LEN, 64'd5);                   // dropped mid-text? here idle
    endtask

    task automatic test_random_texts();
        logic [7:0] p [];
        int m;
        for (int r = 0; r < 55; r++) begin
            m = (r % 10 == 9) ? 32 : $urandom_range(1, 6);
            p = new[m];
            foreach (p[k]) p[k] = 8'($urandom_range(0, 2) + 8'h61);
            if (r % 7 == 3) foreach (p[k]) p[k] = 8'($urandom);
            set_pattern(p, m);
            for (int t = 0; t < 3; t++)
                random_text($urandom_range(1, 20), (r % 7 == 3) ? 0 : 3);
        end
    endtask

    task automatic test_mid_text_write();
        set_pattern('{8'h61, 8'h62}, 2);
        send_byte(8'h61, 1'b0);
        write_reg(bms_pkg::REG_LEN, 64'd1);                   // ignored: text in progress
        write_reg(bms_pkg::REG_PAT0, 64'h63);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
    endtask

    task automatic test_backpressure();
        set_pattern('{8'h61}, 1);
        rx_hold_cycles = 300;
        rx_hold = 1'b1;
        tx_max_gap = 0;
        random_text(60, 2);
        tx_max_gap = 16;
        drain();                                              // sender pauses until all arrive
        rx_max_gap = 0;
        random_text(80, 2);
        rx_max_gap = 16;
    endtask

    initial begin
        errors = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bms_pkg::REG_PAT0;
        cfg_data = '0;
        rx_hold = 1'b0;
        rx_hold_cycles = 0;
        rx_max_gap = 16;
        tx_max_gap = 16;
        for (int k = 0; k < 4; k++) pat_words[k] = '0;
        pat_len_reg = 6'd1;
        align_pos = '0;
        seen = '0;
        wptr = '0;
        tabs_ok = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_mid_text_write();
        test_backpressure();
        test_random_texts();
        drain();
        repeat (100) @(negedge aclk);
        if (errors == 0 && hits_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
